@@ rtl/horizontal_linear_downscaler_macros.svh @@
// Assertion macros shared by the horizontal downscaler RTL.
`ifndef HORIZONTAL_LINEAR_DOWNSCALER_MACROS_SVH
`define HORIZONTAL_LINEAR_DOWNSCALER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HLD_ASSERT_NOW(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define HLD_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ rtl/hld_pkg.sv @@
// Types, constants and codes shared by the horizontal downscaler modules.
package hld_pkg;

    localparam int COMPONENTS = 4;                   // active lanes, 1..4
    localparam int LANES_MAX  = 4;                   // component slots in a request
    localparam int PIX_W      = 8;
    localparam int W_W        = 8;
    localparam int SUM_W      = PIX_W + W_W + 1;     // a*w1 + b*w2
    localparam int DVS_W      = PIX_W + W_W;         // divisor shifted left by up to 7
    localparam int DIV_STEPS  = PIX_W;               // one quotient bit per step
    localparam int CNT_W      = $clog2(DIV_STEPS);

    typedef logic [PIX_W-1:0] t_comp;

    typedef struct packed {
        t_comp comp0;
        t_comp comp1;
        t_comp comp2;
        t_comp comp3;
        logic  row_last;
    } t_in_req;

    typedef struct packed {
        t_comp res0;
        t_comp res1;
        t_comp res2;
        t_comp res3;
    } t_out_req;

    typedef enum logic [0:0] {
        CFG_SCALE_NUM = 1'b0,
        CFG_SCALE_DEN = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_state;

    // Controls broadcast to every lane.
    typedef struct packed {
        logic             load;    // capture current pixel as held pixel
        logic             take;    // capture operand pair for a result
        logic             mul;     // form weighted sum
        logic             step;    // one restoring-divide step
        logic             first;   // first divide step: latch saturation
        logic [W_W-1:0]   w1;
        logic [W_W-1:0]   w2;
        logic [DVS_W-1:0] dvs;     // divisor aligned to current quotient bit
    } t_lane_ctl;

endpackage

@@ rtl/hld_ctrl.sv @@
// Sequencer: scale registers, row weight state and lane control.
module hld_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_row_last,
    input  logic                       i_cfg_valid,
    input  hld_pkg::t_cfg_reg          i_cfg_index,
    input  logic [hld_pkg::W_W-1:0]    i_cfg_data,
    input  logic                       i_out_free,
    output logic                       o_in_stall,
    output logic                       o_cfg_ready,
    output logic                       o_load_out,
    output hld_pkg::t_lane_ctl         o_ctl
);

    hld_pkg::t_state                 r_state, n_state;
    logic [hld_pkg::CNT_W-1:0]       r_cnt, n_cnt;
    logic [hld_pkg::DVS_W-1:0]       r_dvs, n_dvs;
    logic [hld_pkg::W_W-1:0]         r_w1, n_w1;
    logic [hld_pkg::W_W-1:0]         r_w2, n_w2;
    logic [hld_pkg::W_W-1:0]         r_used, n_used;
    logic                            r_have, n_have;
    logic                            r_skip, n_skip;
    logic [hld_pkg::W_W-1:0]         r_num;
    logic [hld_pkg::W_W-1:0]         r_den;

    logic [hld_pkg::W_W-1:0]         w_num_eff;
    logic [hld_pkg::W_W-1:0]         w_den_eff;
    logic [hld_pkg::W_W-1:0]         w_w1;
    logic [hld_pkg::W_W-1:0]         w_w2;
    logic                            w_accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != hld_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num <= hld_pkg::W_W'(1);
            r_den <= hld_pkg::W_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                hld_pkg::CFG_SCALE_NUM: r_num <= i_cfg_data;
                hld_pkg::CFG_SCALE_DEN: r_den <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // zero register acts as one
    assign w_num_eff = (r_num == '0) ? hld_pkg::W_W'(1) : r_num;
    assign w_den_eff = (r_den == '0) ? hld_pkg::W_W'(1) : r_den;
    assign w_w1      = (r_used < w_num_eff) ? (w_num_eff - r_used) : '0;
    assign w_w2      = (w_w1 < w_den_eff) ? (w_den_eff - w_w1) : '0;
    assign w_accept  = i_in_valid && (r_state == hld_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hld_pkg::ST_IDLE;
            r_used  <= '0;
            r_have  <= 1'b0;
            r_skip  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_have  <= n_have;
            r_skip  <= n_skip;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_dvs <= n_dvs;
        r_w1  <= n_w1;
        r_w2  <= n_w2;
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_dvs      = r_dvs;
        n_w1       = r_w1;
        n_w2       = r_w2;
        n_used     = r_used;
        n_have     = r_have;
        n_skip     = r_skip;
        o_load_out = 1'b0;
        o_ctl      = '0;
        o_ctl.w1   = r_w1;
        o_ctl.w2   = r_w2;
        o_ctl.dvs  = r_dvs;

        case (r_state)
            hld_pkg::ST_IDLE: begin
                if (w_accept) begin
                    o_ctl.load = 1'b1;
                    if (r_have && !r_skip) begin
                        o_ctl.take = 1'b1;
                        n_w1       = w_w1;
                        n_w2       = w_w2;
                        n_dvs      = hld_pkg::DVS_W'(w_den_eff) << (hld_pkg::DIV_STEPS - 1);
                        n_state    = hld_pkg::ST_MUL;
                        if (w_w2 >= w_num_eff) begin
                            n_skip = 1'b1;
                            n_used = '0;
                        end else begin
                            n_used = w_w2;
                        end
                    end else begin
                        n_have = 1'b1;
                        n_skip = 1'b0;
                        n_used = '0;
                    end
                    if (i_row_last) begin
                        n_have = 1'b0;
                        n_used = '0;
                        n_skip = 1'b0;
                    end
                end
            end
            hld_pkg::ST_MUL: begin
                o_ctl.mul = 1'b1;
                n_cnt     = '0;
                n_state   = hld_pkg::ST_DIV;
            end
            hld_pkg::ST_DIV: begin
                o_ctl.step  = 1'b1;
                o_ctl.first = (r_cnt == '0);
                n_dvs       = r_dvs >> 1;
                n_cnt       = r_cnt + hld_pkg::CNT_W'(1);
                if (r_cnt == hld_pkg::CNT_W'(hld_pkg::DIV_STEPS - 1)) begin
                    n_state = hld_pkg::ST_DONE;
                end
            end
            hld_pkg::ST_DONE: begin
                if (i_out_free) begin
                    o_load_out = 1'b1;
                    n_state    = hld_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hld_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/hld_lane.sv @@
// One component lane: held pixel, weighted sum and bit-serial divide.
module hld_lane (
    input  logic                  i_clk,
    input  hld_pkg::t_lane_ctl    i_ctl,
    input  hld_pkg::t_comp        i_cur,
    output hld_pkg::t_comp        o_res
);

    hld_pkg::t_comp                  r_held;
    hld_pkg::t_comp                  r_a;
    hld_pkg::t_comp                  r_b;
    logic [hld_pkg::SUM_W-1:0]       r_rem, n_rem;
    hld_pkg::t_comp                  r_q;
    logic                            r_sat;

    logic [hld_pkg::PIX_W+hld_pkg::W_W-1:0] w_pa;
    logic [hld_pkg::PIX_W+hld_pkg::W_W-1:0] w_pb;
    logic                            w_fit;
    logic                            w_sat;

    assign w_pa  = r_a * i_ctl.w1;
    assign w_pb  = r_b * i_ctl.w2;
    assign w_fit = (r_rem >= {1'b0, i_ctl.dvs});
    // quotient above 255 iff sum >= den << 8; dvs holds den << 7 on the first step
    assign w_sat = (r_rem >= {i_ctl.dvs, 1'b0});
    assign n_rem = w_fit ? (r_rem - {1'b0, i_ctl.dvs}) : r_rem;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_held <= i_cur;
        end
        if (i_ctl.take) begin
            r_a <= r_held;
            r_b <= i_cur;
        end
        if (i_ctl.mul) begin
            r_rem <= hld_pkg::SUM_W'(w_pa) + hld_pkg::SUM_W'(w_pb);
            r_q   <= '0;
        end
        if (i_ctl.step) begin
            r_rem <= n_rem;
            r_q   <= {r_q[hld_pkg::PIX_W-2:0], w_fit};
        end
        if (i_ctl.first) begin
            r_sat <= w_sat;
        end
    end

    assign o_res = r_sat ? '1 : r_q;

endmodule

@@ rtl/hld_merge.sv @@
// Output stage: gathers lane quotients into one result request.
module hld_merge (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_load,
    input  logic                                        i_stall,
    input  logic [hld_pkg::LANES_MAX-1:0][hld_pkg::PIX_W-1:0] i_res,
    output logic                                        o_valid,
    output hld_pkg::t_out_req                           o_data,
    output logic                                        o_free
);

    logic              r_valid;
    hld_pkg::t_out_req r_data;

    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data.res0 <= i_res[0];
            r_data.res1 <= i_res[1];
            r_data.res2 <= i_res[2];
            r_data.res3 <= i_res[3];
        end
    end

endmodule

@@ rtl/horizontal_linear_downscaler.sv @@
// Top level of the horizontal linear downscaler: lanes, sequencer, output stage.
//
//  channel   direction  handshake              payload
//  in        to block   i_in_valid/o_in_stall  i_in_data  (hld_pkg::t_in_req)
//  out       from block o_out_valid/i_out_stall o_out_data (hld_pkg::t_out_req)
//  cfg       to block   i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
//  A pixel that yields no output (row start, skip) is captured while the sequencer stays idle.
//  A pixel that yields output goes through capture, multiply, 8 divide
//  steps (one quotient bit each, in every lane), hand-off to the output register.
//  The output register frees the core: the next request is taken while a result waits.
//  o_in_stall is high while the sequencer is busy or holds a result for a full
//  output register. Reset is synchronous, active low; scale registers reset to 1.
module horizontal_linear_downscaler (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  hld_pkg::t_in_req        i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output hld_pkg::t_out_req       o_out_data,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  hld_pkg::t_cfg_reg       i_cfg_index,
    input  logic [hld_pkg::W_W-1:0] i_cfg_data
);

    `include "horizontal_linear_downscaler_macros.svh"

    hld_pkg::t_lane_ctl                                 w_ctl;
    logic                                               w_load_out;
    logic                                               w_out_free;
    logic [hld_pkg::LANES_MAX-1:0][hld_pkg::PIX_W-1:0]  w_cur;
    logic [hld_pkg::LANES_MAX-1:0][hld_pkg::PIX_W-1:0]  w_res;

    // component slots of the request, lane k takes slot k
    assign w_cur[0] = i_in_data.comp0;
    assign w_cur[1] = i_in_data.comp1;
    assign w_cur[2] = i_in_data.comp2;
    assign w_cur[3] = i_in_data.comp3;

    // Sequencer: weight update happens on the accepting edge, so row and skip
    // bookkeeping is complete before the divide even starts.
    hld_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_row_last  (i_in_data.row_last),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_free  (w_out_free),
        .o_in_stall  (o_in_stall),
        .o_cfg_ready (o_cfg_ready),
        .o_load_out  (w_load_out),
        .o_ctl       (w_ctl)
    );

    // One lane per active component; unused slots read as zero.
    for (genvar k = 0; k < hld_pkg::LANES_MAX; k++) begin : g_lane
        if (k < hld_pkg::COMPONENTS) begin : g_on
            hld_lane u_lane (
                .i_clk (i_clk),
                .i_ctl (w_ctl),
                .i_cur (w_cur[k]),
                .o_res (w_res[k])
            );
        end else begin : g_off
            assign w_res[k] = '0;
        end
    end

    hld_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load_out),
        .i_stall (i_out_stall),
        .i_res   (w_res),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .o_free  (w_out_free)
    );

    // A result is handed over only by a busy core.
    `HLD_ASSERT_NOW(a_load_busy, i_clk, i_rst_n, w_load_out, o_in_stall, "result load while idle")
    // A pending, stalled result is never overwritten.
    `HLD_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, w_load_out && o_out_valid, !i_out_stall, "result overwritten")
    // A hand-off always shows up on the output.
    `HLD_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, w_load_out, o_out_valid, "loaded result not valid")

endmodule

@@ verif/horizontal_linear_downscaler_tb.sv @@
// Self-checking testbench for the horizontal linear downscaler.
`timescale 1ns / 100ps

module horizontal_linear_downscaler_tb;

    localparam int PHASES       = 10;
    localparam int PHASE_PIXELS = 98;
    localparam int SETTLE_CYCLES = 16;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_in_valid  = 1'b0;
    logic                       o_in_stall;
    hld_pkg::t_in_req           i_in_data   = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    hld_pkg::t_out_req          o_out_data;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    hld_pkg::t_cfg_reg          i_cfg_index = hld_pkg::CFG_SCALE_NUM;
    logic [hld_pkg::W_W-1:0]    i_cfg_data  = '0;

    horizontal_linear_downscaler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Scaler model state: register copies plus row state
    // ------------------------------------------------------------------
    logic [7:0] cfg_num = 8'd1;
    logic [7:0] cfg_den = 8'd1;
    logic [7:0] held_comp [4];
    logic [7:0] used_w;
    bit         have_held;
    bit         skip_next;

    hld_pkg::t_out_req blend_due [$];   // blended pixels still owed by the block

    int mismatch_count  = 0;
    int pixels_sent     = 0;
    int pixels_absorbed = 0;
    int blends_seen     = 0;
    int settings_used   = 0;

    bit tx_gaps_on = 1'b1;          // sender idles in short bursts
    bit rx_stall_on = 1'b1;         // receiver stalls in short bursts

    task automatic log_mismatch(string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Advances the row state by one pixel; returns 1 with the blend when one is due.
    function automatic bit blend_step(input hld_pkg::t_in_req px,
                                      output hld_pkg::t_out_req res);
        logic [7:0]  cur [4];
        logic [7:0]  lane [4];
        int unsigned num, den, w1, w2, q;
        cur = '{px.comp0, px.comp1, px.comp2, px.comp3};
        for (int k = 0; k < 4; k++) begin
            if (k >= hld_pkg::COMPONENTS) cur[k] = '0;
            lane[k] = '0;
        end
        res = '0;
        // a zero register behaves as one
        num = (cfg_num == 0) ? 1 : cfg_num;
        den = (cfg_den == 0) ? 1 : cfg_den;

        // row start or skip: just capture the pixel
        if (!have_held || skip_next) begin
            held_comp = cur;
            have_held = 1'b1;
            skip_next = 1'b0;
            used_w    = '0;
            if (px.row_last) begin
                have_held = 1'b0;
            end
            return 1'b0;
        end

        w1 = (used_w < num) ? num - used_w : 0;
        w2 = (w1 < den) ? den - w1 : 0;     // ratio above one: w2 clamps to zero
        for (int k = 0; k < hld_pkg::COMPONENTS; k++) begin
            q = (held_comp[k] * w1 + cur[k] * w2) / den;
            lane[k] = (q > 255) ? 8'hFF : q[7:0];
        end
        res.res0 = lane[0];
        res.res1 = lane[1];
        res.res2 = lane[2];
        res.res3 = lane[3];

        used_w    = w2[7:0];
        held_comp = cur;
        if (used_w >= num) begin
            skip_next = 1'b1;
            used_w    = '0;
        end
        if (px.row_last) begin
            have_held = 1'b0;
            used_w    = '0;
            skip_next = 1'b0;
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Directed plan: pixel requests and register writes in order
    // ------------------------------------------------------------------
    typedef struct {
        bit                 is_cfg;
        hld_pkg::t_cfg_reg  cfg_idx;
        logic [7:0]         cfg_val;
        hld_pkg::t_in_req   px;
        bit                 typed;      // expected blend given by hand
        hld_pkg::t_out_req  res;
    } t_plan_row;

    t_plan_row test_plan [$];

    function automatic void add_pix(logic [31:0] comps, bit last);
        t_plan_row row;
        row        = '{cfg_idx: hld_pkg::CFG_SCALE_NUM, default: '0};
        row.px     = hld_pkg::t_in_req'({comps, last});
        test_plan.push_back(row);
    endfunction

    function automatic void add_blend(logic [31:0] comps, bit last, logic [31:0] want);
        t_plan_row row;
        row        = '{cfg_idx: hld_pkg::CFG_SCALE_NUM, default: '0};
        row.px     = hld_pkg::t_in_req'({comps, last});
        row.typed  = 1'b1;
        row.res    = hld_pkg::t_out_req'(want);
        test_plan.push_back(row);
    endfunction

    function automatic void add_cfg(hld_pkg::t_cfg_reg idx, logic [7:0] val);
        t_plan_row row;
        row         = '{cfg_idx: hld_pkg::CFG_SCALE_NUM, default: '0};
        row.is_cfg  = 1'b1;
        row.cfg_idx = idx;
        row.cfg_val = val;
        test_plan.push_back(row);
    endfunction

    // ------------------------------------------------------------------
    // Request drivers
    // ------------------------------------------------------------------
    task automatic send_pixel(hld_pkg::t_in_req px, bit typed, hld_pkg::t_out_req typed_res);
        hld_pkg::t_out_req res;
        bit                has;
        if (i_cfg_valid) i_cfg_valid <= 1'b0;
        i_in_valid <= 1'b1;
        i_in_data  <= px;
        do @(posedge i_clk); while (o_in_stall);
        has = blend_step(px, res);
        pixels_sent++;
        if (has) blend_due.push_back(typed ? typed_res : res);
        else pixels_absorbed++;
        if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    // Leaves valid high so back-to-back writes keep one assignment per step.
    task automatic write_reg(hld_pkg::t_cfg_reg idx, logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == hld_pkg::CFG_SCALE_NUM) cfg_num = val;
        else cfg_den = val;
    endtask

    // Stop sending, collect every owed blend, then let absorbed pixels finish.
    task automatic drain_and_settle();
        i_in_valid <= 1'b0;
        while (blend_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall bursts, result checking
    // ------------------------------------------------------------------
    int stall_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || !rx_stall_on) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 2);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic check_lane(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            log_mismatch($sformatf("%s got %02h want %02h (blend %0d)",
                                   name, got, want, blends_seen));
    endtask

    always @(posedge i_clk) begin
        hld_pkg::t_out_req want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (blend_due.size() == 0) begin
                log_mismatch($sformatf("result %08h with no blend owed", o_out_data));
            end else begin
                want = blend_due.pop_front();
                check_lane("res0", o_out_data.res0, want.res0);
                check_lane("res1", o_out_data.res1, want.res1);
                check_lane("res2", o_out_data.res2, want.res2);
                check_lane("res3", o_out_data.res3, want.res3);
            end
            blends_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int               sent_in_phase;
        int               len;
        bit               paused;
        bit               prev_pix;
        bit               well_formed;
        logic [7:0]       num, den;
        hld_pkg::t_in_req px;

        used_w    = '0;
        have_held = 1'b0;
        skip_next = 1'b0;
        for (int k = 0; k < 4; k++) held_comp[k] = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset scale 1/1: every pixel after the row's first echoes the previous one.
        add_pix  (32'h00000000, 1'b0);                     // row start, absorbed
        add_blend(32'hFFFFFFFF, 1'b0, 32'h00000000);
        add_blend(32'h00FF00FF, 1'b0, 32'hFFFFFFFF);
        add_blend(32'hA55A0FF0, 1'b1, 32'h00FF00FF);       // row end
        add_pix  (32'h12345678, 1'b1);                     // one-pixel row
        add_pix  (32'h01020304, 1'b0);
        add_blend(32'h80402010, 1'b0, 32'h01020304);
        add_blend(32'h7F3FC0E1, 1'b1, 32'h80402010);
        // Ratio above one: w2 clamps, quotients saturate.
        add_cfg  (hld_pkg::CFG_SCALE_NUM, 8'd255);
        add_cfg  (hld_pkg::CFG_SCALE_DEN, 8'd1);
        add_pix  (32'hFF00FF01, 1'b0);
        add_blend(32'h00FF0000, 1'b1, 32'hFF00FFFF);
        // Zero registers behave as one.
        add_cfg  (hld_pkg::CFG_SCALE_NUM, 8'd0);
        add_cfg  (hld_pkg::CFG_SCALE_DEN, 8'd0);
        add_pix  (32'h11223344, 1'b0);
        add_blend(32'h55667788, 1'b1, 32'h11223344);
        // 2/3 hits the skip path mid-row.
        add_cfg  (hld_pkg::CFG_SCALE_NUM, 8'd2);
        add_cfg  (hld_pkg::CFG_SCALE_DEN, 8'd3);
        add_pix  (32'h00FF00FF, 1'b0);
        add_pix  (32'hFF00FF00, 1'b0);
        add_pix  (32'hFFFFFFFF, 1'b0);
        add_pix  (32'h80808080, 1'b0);
        add_pix  (32'h00000000, 1'b0);
        add_pix  (32'hFEDCBA98, 1'b1);
        // Both registers at the top.
        add_cfg  (hld_pkg::CFG_SCALE_NUM, 8'd255);
        add_cfg  (hld_pkg::CFG_SCALE_DEN, 8'd255);
        add_pix  (32'h01010101, 1'b0);
        add_pix  (32'hFFFFFFFF, 1'b0);
        add_pix  (32'h7F80817E, 1'b1);

        settings_used = 1;
        prev_pix      = 1'b1;
        foreach (test_plan[i]) begin
            if (test_plan[i].is_cfg) begin
                if (prev_pix) begin
                    drain_and_settle();
                    settings_used++;
                end
                write_reg(test_plan[i].cfg_idx, test_plan[i].cfg_val);
                prev_pix = 1'b0;
            end else begin
                send_pixel(test_plan[i].px, test_plan[i].typed, test_plan[i].res);
                prev_pix = 1'b1;
            end
        end

        // Random phases, each under its own scale setting.
        for (int ph = 0; ph < PHASES; ph++) begin
            drain_and_settle();
            // some phases run without idling; the closing ones are always clean
            tx_gaps_on  = (ph < PHASES - 2) && (ph % 4 != 1);
            rx_stall_on = (ph < PHASES - 2) && (ph % 4 != 3);

            case (ph)
                0: begin num = 8'd128; den = 8'd255; end    // ratio just above 1/2
                1: begin num = 8'd255; den = 8'd255; end
                2: begin num = 8'd1;   den = 8'd1;   end
                3: begin num = 8'd255; den = 8'd1;   end
                4: begin num = 8'd0;   den = 8'($urandom_range(1, 255)); end
                default: begin
                    if ($urandom_range(0, 3) != 0) begin
                        den = 8'($urandom_range(1, 255));
                        num = 8'($urandom_range((den + 1) / 2, den));
                    end else begin
                        num = 8'($urandom_range(0, 255));
                        den = 8'($urandom_range(0, 255));
                    end
                end
            endcase
            if ($urandom_range(0, 1)) begin
                write_reg(hld_pkg::CFG_SCALE_NUM, num);
                write_reg(hld_pkg::CFG_SCALE_DEN, den);
            end else begin
                write_reg(hld_pkg::CFG_SCALE_DEN, den);
                write_reg(hld_pkg::CFG_SCALE_NUM, num);
            end
            settings_used++;

            sent_in_phase = 0;
            paused        = 1'b0;
            while (sent_in_phase < PHASE_PIXELS) begin
                // one hold-off mid-phase until the block has handed back everything
                if (ph == 2 && sent_in_phase >= PHASE_PIXELS / 2 && !paused) begin
                    i_in_valid <= 1'b0;
                    while (blend_due.size() != 0) @(posedge i_clk);
                    paused = 1'b1;
                end
                // mostly whole rows; sometimes a run with random row ends
                well_formed = ($urandom_range(0, 6) != 0);
                len = well_formed ? $urandom_range(1, 16) : $urandom_range(1, 5);
                for (int j = 0; j < len; j++) begin
                    px.comp0    = 8'($urandom_range(0, 255));
                    px.comp1    = 8'($urandom_range(0, 255));
                    px.comp2    = 8'($urandom_range(0, 255));
                    px.comp3    = 8'($urandom_range(0, 255));
                    px.row_last = well_formed ? (j == len - 1) : 1'($urandom_range(0, 1));
                    send_pixel(px, 1'b0, '0);
                    sent_in_phase++;
                end
            end
        end

        drain_and_settle();
        $display("Covered %0d pixels under %0d scale settings: %0d blends checked, %0d absorbed.",
                 pixels_sent, settings_used, blends_seen, pixels_absorbed);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches found", mismatch_count);
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("Timeout with %0d blends still owed", blend_due.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/hld_pkg.sv
rtl/hld_ctrl.sv
rtl/hld_lane.sv
rtl/hld_merge.sv
rtl/horizontal_linear_downscaler.sv
verif/horizontal_linear_downscaler_tb.sv
